// ===== hw/rtl/htw_pkg.sv =====
package htw_pkg;

    localparam int unsigned WHEEL_SLOTS_DEF = 1024;
    localparam int unsigned NUM_TIMERS_DEF  = 16;

    localparam int unsigned ACT_W   = 2;
    localparam int unsigned ID_W    = 4;
    localparam int unsigned ID_EXT_W = 6;
    localparam int unsigned WAIT_W  = 16;
    localparam int unsigned TAG_W   = 16;
    localparam int unsigned FT_W    = 10;
    localparam int unsigned REM_W   = 10;
    localparam int unsigned LAP_W   = 6;
    localparam int unsigned LAP_MAX = 63;
    localparam int unsigned DIV_REM_W = 17;

    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd3;

    typedef struct packed {
        logic              start;
        logic [WAIT_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [WAIT_W-1:0]    quot;
        logic [DIV_REM_W-1:0] rem;
    } div_res_t;

endpackage

// ===== hw/rtl/htw_if.sv =====
interface htw_in_if;
    import htw_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ID_W-1:0]   timer_id;
    logic [WAIT_W-1:0] delay_ticks;
    logic [TAG_W-1:0]  tag;
    logic [FT_W-1:0]   frame_time;

    modport source (output valid, action, timer_id, delay_ticks, tag, frame_time, input ready);
    modport sink (input valid, action, timer_id, delay_ticks, tag, frame_time, output ready);
endinterface

interface htw_out_if;
    import htw_pkg::*;

    logic             valid;
    logic             ready;
    logic             status;
    logic             fired;
    logic [ID_W-1:0]  fired_id;
    logic [TAG_W-1:0] fired_tag;
    logic [REM_W-1:0] remaining;
    logic             last;

    modport source (output valid, status, fired, fired_id, fired_tag, remaining, last,
                    input ready);
    modport sink (input valid, status, fired, fired_id, fired_tag, remaining, last,
                  output ready);
endinterface

// ===== hw/rtl/htw_ram.sv =====
module htw_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/htw_div.sv =====
module htw_div #(
    parameter int unsigned DIVISOR = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  htw_pkg::div_req_t req,
    output htw_pkg::div_res_t res
);
    import htw_pkg::*;

    // reciprocal multiply, exact for every dividend of WAIT_W bits
    localparam int unsigned          SHIFT   = WAIT_W + $clog2(DIVISOR);
    localparam int unsigned          RECIP_W = WAIT_W + 1;
    localparam int unsigned          PROD_W  = WAIT_W + RECIP_W;
    localparam longint unsigned      RECIP_L = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam logic [RECIP_W-1:0]   RECIP   = RECIP_W'(RECIP_L);
    localparam logic [DIV_REM_W-1:0] DIV_C   = DIV_REM_W'(DIVISOR);

    logic                 mul_reg, mul_next;
    logic                 sub_reg, sub_next;
    logic                 done_reg, done_next;
    logic [WAIT_W-1:0]    dvd_reg, dvd_next;
    logic [WAIT_W-1:0]    quot_reg, quot_next;
    logic [DIV_REM_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    back;

    // quotient in the multiply stage, remainder in the subtract stage
    always_comb
    begin
        mul_next  = req.start;
        sub_next  = mul_reg;
        done_next = sub_reg;
        dvd_next  = req.start ? req.dividend : dvd_reg;
        prod      = PROD_W'(dvd_reg) * PROD_W'(RECIP);
        quot_next = mul_reg ? WAIT_W'(prod >> SHIFT) : quot_reg;
        back      = PROD_W'(quot_reg) * PROD_W'(DIV_C);
        rem_next  = sub_reg ? DIV_REM_W'(PROD_W'(dvd_reg) - back) : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= mul_next;
            sub_reg  <= sub_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

// ===== hw/rtl/hashed_timer_wheel.sv =====
// start: two-stage reciprocal divide, then a timer memory write; stop, rejected start
// or rejected read: straight to the response; read: one timer memory read
// tick: divide for the frame slot remainder, then per visited slot scan every timer,
// reading memory only for armed ones, then the closing word; new input only in idle
// a stalled output holds the scan or the closing word
// reset: armed flags cleared, current slot set to last slot, timer memory not cleared
module hashed_timer_wheel #(
    parameter int unsigned WHEEL_SLOTS = htw_pkg::WHEEL_SLOTS_DEF,
    parameter int unsigned NUM_TIMERS  = htw_pkg::NUM_TIMERS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    htw_in_if.sink    in_ch,
    htw_out_if.source out_ch
);
    import htw_pkg::*;

    localparam int unsigned SLOT_W = $clog2(WHEEL_SLOTS);
    localparam int unsigned IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int unsigned RAM_W  = SLOT_W + LAP_W + TAG_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WHEEL_SLOTS - 1);
    localparam logic [IDX_W-1:0]  SCAN_LAST = IDX_W'(NUM_TIMERS - 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIV       = 3'd1;
    localparam logic [2:0] S_RD_REQ    = 3'd2;
    localparam logic [2:0] S_RD_RSP    = 3'd3;
    localparam logic [2:0] S_SCAN_RD   = 3'd4;
    localparam logic [2:0] S_SCAN_PROC = 3'd5;
    localparam logic [2:0] S_RESP      = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [SLOT_W-1:0]     goal_reg, goal_next;
    logic [IDX_W-1:0]      scan_reg, scan_next;
    logic [ACT_W-1:0]      act_reg, act_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic                  rsp_status_reg, rsp_status_next;
    logic [REM_W-1:0]      rsp_rem_reg, rsp_rem_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_status_reg, out_status_next;
    logic                  out_fired_reg, out_fired_next;
    logic [ID_W-1:0]       out_id_reg, out_id_next;
    logic [TAG_W-1:0]      out_tag_reg, out_tag_next;
    logic [REM_W-1:0]      out_rem_reg, out_rem_next;
    logic                  out_last_reg, out_last_next;

    div_req_t              div_req;
    div_res_t              div_res;

    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [RAM_W-1:0]      ram_wdata, ram_rdata;
    logic [SLOT_W-1:0]     rd_slot;
    logic [LAP_W-1:0]      rd_laps;
    logic [TAG_W-1:0]      rd_tag;

    logic [ID_EXT_W-1:0]   in_id_ext;
    logic [IDX_W-1:0]      in_idx;
    logic                  in_id_ok;
    logic                  out_free;
    logic [SLOT_W-1:0]     cur_inc;
    logic [SLOT_W:0]       tgt_sum;
    logic [SLOT_W-1:0]     tgt_slot;
    logic [WAIT_W-1:0]     q_adj;
    logic [LAP_W-1:0]      laps_new;
    logic [SLOT_W:0]       diff;
    logic [SLOT_W-1:0]     left_slot;
    logic [WAIT_W-1:0]     left_wide;
    logic [ID_EXT_W-1:0]   scan_ext;
    logic                  do_adv;

    htw_div #(
        .DIVISOR (WHEEL_SLOTS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    htw_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_TIMERS),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign {rd_slot, rd_laps, rd_tag} = ram_rdata;

    assign in_id_ext = ID_EXT_W'(in_ch.timer_id);
    assign in_idx    = in_id_ext[IDX_W-1:0];
    assign in_id_ok  = (ID_EXT_W + 1)'(in_id_ext) < (ID_EXT_W + 1)'(NUM_TIMERS);
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign cur_inc   = (cur_reg == SLOT_LAST) ? '0 : cur_reg + 1'b1;
    assign scan_ext  = ID_EXT_W'(scan_reg);

    // target slot and lap count for a start
    assign tgt_sum  = (SLOT_W + 1)'(cur_reg) + (SLOT_W + 1)'(div_res.rem[SLOT_W-1:0]);
    assign tgt_slot = (tgt_sum >= (SLOT_W + 1)'(WHEEL_SLOTS))
                    ? SLOT_W'(tgt_sum - (SLOT_W + 1)'(WHEEL_SLOTS)) : tgt_sum[SLOT_W-1:0];
    assign q_adj    = (div_res.rem == '0) ? div_res.quot - 1'b1 : div_res.quot;
    assign laps_new = (q_adj > WAIT_W'(LAP_MAX)) ? LAP_W'(LAP_MAX) : q_adj[LAP_W-1:0];

    // slots left for a read
    assign diff      = (SLOT_W + 1)'(rd_slot) - (SLOT_W + 1)'(cur_reg);
    assign left_slot = diff[SLOT_W] ? SLOT_W'(diff + (SLOT_W + 1)'(WHEEL_SLOTS))
                                    : diff[SLOT_W-1:0];
    assign left_wide = WAIT_W'(left_slot);

    assign in_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        armed_next      = armed_reg;
        cur_next        = cur_reg;
        goal_next       = goal_reg;
        scan_next       = scan_reg;
        act_next        = act_reg;
        idx_next        = idx_reg;
        tag_next        = tag_reg;
        rsp_status_next = rsp_status_reg;
        rsp_rem_next    = rsp_rem_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_fired_next  = out_fired_reg;
        out_id_next     = out_id_reg;
        out_tag_next    = out_tag_reg;
        out_rem_next    = out_rem_reg;
        out_last_next   = out_last_reg;
        div_req         = '0;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {tgt_slot, laps_new, tag_reg};
        ram_re          = 1'b0;
        ram_raddr       = scan_reg;
        do_adv          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    act_next        = in_ch.action;
                    idx_next        = in_idx;
                    tag_next        = in_ch.tag;
                    rsp_status_next = 1'b0;
                    rsp_rem_next    = '0;
                    case (in_ch.action)
                        ACT_TICK:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = WAIT_W'(in_ch.frame_time);
                            state_next       = S_DIV;
                        end
                        ACT_START:
                        begin
                            if (in_ch.delay_ticks == '0 || !in_id_ok)
                            begin
                                rsp_status_next = 1'b1;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = in_ch.delay_ticks;
                                state_next       = S_DIV;
                            end
                        end
                        ACT_STOP:
                        begin
                            if (!in_id_ok || !armed_reg[in_idx])
                            begin
                                rsp_status_next = 1'b1;
                            end
                            else
                            begin
                                armed_next[in_idx] = 1'b0;
                            end
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            if (!in_id_ok || !armed_reg[in_idx])
                            begin
                                rsp_status_next = 1'b1;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_RD_REQ;
                            end
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    if (act_reg == ACT_TICK)
                    begin
                        goal_next  = div_res.rem[SLOT_W-1:0];
                        cur_next   = cur_inc;
                        scan_next  = '0;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        ram_we              = 1'b1;
                        armed_next[idx_reg] = 1'b1;
                        state_next          = S_RESP;
                    end
                end
            end
            S_RD_REQ:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg;
                state_next = S_RD_RSP;
            end
            S_RD_RSP:
            begin
                armed_next[idx_reg] = 1'b0;
                rsp_rem_next        = left_wide[REM_W-1:0];
                state_next          = S_RESP;
            end
            S_SCAN_RD:
            begin
                if (armed_reg[scan_reg])
                begin
                    ram_re     = 1'b1;
                    state_next = S_SCAN_PROC;
                end
                else
                begin
                    do_adv = 1'b1;
                end
            end
            S_SCAN_PROC:
            begin
                if (rd_slot != cur_reg)
                begin
                    state_next = S_SCAN_RD;
                    do_adv     = 1'b1;
                end
                else if (rd_laps != '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = scan_reg;
                    ram_wdata  = {rd_slot, rd_laps - 1'b1, rd_tag};
                    state_next = S_SCAN_RD;
                    do_adv     = 1'b1;
                end
                else if (out_free)
                begin
                    armed_next[scan_reg] = 1'b0;
                    out_valid_next       = 1'b1;
                    out_status_next      = 1'b0;
                    out_fired_next       = 1'b1;
                    out_id_next          = scan_ext[ID_W-1:0];
                    out_tag_next         = rd_tag;
                    out_rem_next         = '0;
                    out_last_next        = 1'b0;
                    state_next           = S_SCAN_RD;
                    do_adv               = 1'b1;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rsp_status_reg;
                    out_fired_next  = 1'b0;
                    out_id_next     = '0;
                    out_tag_next    = '0;
                    out_rem_next    = rsp_rem_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // next timer, next slot or end of tick
        if (do_adv)
        begin
            if (scan_reg != SCAN_LAST)
            begin
                scan_next = scan_reg + 1'b1;
            end
            else if (cur_reg == goal_reg)
            begin
                rsp_status_next = 1'b0;
                rsp_rem_next    = '0;
                state_next      = S_RESP;
            end
            else
            begin
                cur_next  = cur_inc;
                scan_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            armed_reg     <= '0;
            cur_reg       <= SLOT_LAST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        goal_reg       <= goal_next;
        scan_reg       <= scan_next;
        act_reg        <= act_next;
        idx_reg        <= idx_next;
        tag_reg        <= tag_next;
        rsp_status_reg <= rsp_status_next;
        rsp_rem_reg    <= rsp_rem_next;
        out_status_reg <= out_status_next;
        out_fired_reg  <= out_fired_next;
        out_id_reg     <= out_id_next;
        out_tag_reg    <= out_tag_next;
        out_rem_reg    <= out_rem_next;
        out_last_reg   <= out_last_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.status    = out_status_reg;
    assign out_ch.fired     = out_fired_reg;
    assign out_ch.fired_id  = out_id_reg;
    assign out_ch.fired_tag = out_tag_reg;
    assign out_ch.remaining = out_rem_reg;
    assign out_ch.last      = out_last_reg;

    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= SLOT_LAST)
        else $error("current slot out of range");

    a_fired_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fired_reg) |-> (!out_last_reg && !out_status_reg))
        else $error("fired word marked last or error");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("timer memory written while idle");

    a_scan_goal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_RD || state_reg == S_SCAN_PROC) |-> (goal_reg <= SLOT_LAST))
        else $error("tick goal slot out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg)
        else $error("result word dropped while stalled");

endmodule

// ===== tb/htw_checker.sv =====
`timescale 1ns / 1ps

module htw_checker
    import htw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    htw_in_if    in_ch,
    htw_out_if   out_ch,
    output int   errors,
    output int   pending,
    output int   fire_count
);

    localparam int SLOTS  = WHEEL_SLOTS_DEF;
    localparam int TIMERS = NUM_TIMERS_DEF;

    typedef struct packed {
        logic             status;
        logic             fired;
        logic [ID_W-1:0]  fired_id;
        logic [TAG_W-1:0] fired_tag;
        logic [REM_W-1:0] remaining;
        logic             last;
    } timer_result_t;

    logic              armed     [TIMERS];
    logic [REM_W-1:0]  slot_of   [TIMERS];
    logic [LAP_W-1:0]  laps_of   [TIMERS];
    logic [TAG_W-1:0]  tag_of    [TIMERS];
    int                now_slot;
    timer_result_t     expected_q[$];

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic timer_result_t make_result(logic st, logic fr, int id, int tg,
                                                  int rem, logic lst);
        timer_result_t r;
        r.status    = st;
        r.fired     = fr;
        r.fired_id  = id[ID_W-1:0];
        r.fired_tag = tg[TAG_W-1:0];
        r.remaining = rem[REM_W-1:0];
        r.last      = lst;
        return r;
    endfunction

    task automatic expire_slot(int s);
        for (int i = 0; i < TIMERS; i++)
        begin
            if (armed[i] && slot_of[i] == s)
            begin
                if (laps_of[i] == 0)
                begin
                    armed[i] = 1'b0;
                    expected_q.push_back(make_result(1'b0, 1'b1, i, tag_of[i], 0, 1'b0));
                end
                else
                    laps_of[i]--;
            end
        end
    endtask

    task automatic predict_word(logic [ACT_W-1:0] act, int id, int wt, int tg, int ft);
        int laps;
        case (act)
            ACT_TICK:
            begin
                now_slot = (now_slot + 1) % SLOTS;
                while (now_slot != ft % SLOTS)
                begin
                    expire_slot(now_slot);
                    now_slot = (now_slot + 1) % SLOTS;
                end
                expire_slot(now_slot);
                expected_q.push_back(make_result(1'b0, 1'b0, 0, 0, 0, 1'b1));
            end
            ACT_START:
            begin
                if (wt == 0 || id >= TIMERS)
                    expected_q.push_back(make_result(1'b1, 1'b0, 0, 0, 0, 1'b1));
                else
                begin
                    laps = (wt % SLOTS == 0) ? (wt - 1) / SLOTS : wt / SLOTS;
                    if (laps > LAP_MAX)
                        laps = LAP_MAX;
                    armed[id]   = 1'b1;
                    slot_of[id] = REM_W'((now_slot + wt) % SLOTS);
                    laps_of[id] = LAP_W'(laps);
                    tag_of[id]  = tg[TAG_W-1:0];
                    expected_q.push_back(make_result(1'b0, 1'b0, 0, 0, 0, 1'b1));
                end
            end
            default:
            begin
                if (id >= TIMERS || !armed[id])
                    expected_q.push_back(make_result(1'b1, 1'b0, 0, 0, 0, 1'b1));
                else
                begin
                    armed[id] = 1'b0;
                    expected_q.push_back(make_result(1'b0, 1'b0, 0, 0,
                        (act == ACT_READ) ? (slot_of[id] + SLOTS - now_slot) % SLOTS : 0,
                        1'b1));
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        if (!rst_n)
        begin
            foreach (armed[i])
                armed[i] = 1'b0;
            now_slot   = SLOTS - 1;
            expected_q.delete();
            errors     = 0;
            fire_count = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_word(in_ch.action, in_ch.timer_id, in_ch.delay_ticks, in_ch.tag,
                             in_ch.frame_time);
            if (out_ch.valid && out_ch.ready)
            begin
                if (out_ch.fired)
                    fire_count++;
                if (expected_q.size() == 0)
                    report_mismatch("unexpected word", out_ch.last, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (out_ch.status !== want.status)
                        report_mismatch("status", out_ch.status, want.status);
                    if (out_ch.fired !== want.fired)
                        report_mismatch("fired", out_ch.fired, want.fired);
                    if (out_ch.fired_id !== want.fired_id)
                        report_mismatch("fired_id", out_ch.fired_id, want.fired_id);
                    if (out_ch.fired_tag !== want.fired_tag)
                        report_mismatch("fired_tag", out_ch.fired_tag, want.fired_tag);
                    if (out_ch.remaining !== want.remaining)
                        report_mismatch("remaining", out_ch.remaining, want.remaining);
                    if (out_ch.last !== want.last)
                        report_mismatch("last", out_ch.last, want.last);
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== tb/tb_hashed_timer_wheel.sv =====
`timescale 1ns / 1ps

module tb_hashed_timer_wheel;
    import htw_pkg::*;

    localparam int SLOTS      = WHEEL_SLOTS_DEF;
    localparam int STALL_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   fire_count;
    int   idle_in;
    int   idle_out;
    int   cur_slot;
    int   word_count;
    int   stall_cycles;

    htw_in_if  in_ch ();
    htw_out_if out_ch ();

    hashed_timer_wheel dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    htw_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .errors     (errors),
        .pending    (pending),
        .fire_count (fire_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= idle_out);

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("hashed_timer_wheel regression: fail");
            $finish;
        end
    end

    task automatic send_word(logic [ACT_W-1:0] act, int id, int wt, int tg, int ft);
        while ($urandom_range(99) < idle_in)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.timer_id    <= id[ID_W-1:0];
        in_ch.delay_ticks <= wt[WAIT_W-1:0];
        in_ch.tag         <= tg[TAG_W-1:0];
        in_ch.frame_time  <= ft[FT_W-1:0];
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (act == ACT_TICK)
            cur_slot = ft % SLOTS;
        word_count++;
    endtask

    task automatic tick_to(int ft);
        send_word(ACT_TICK, $urandom_range(15), $urandom, $urandom, ft);
    endtask

    task automatic random_word();
        int pick;
        int wt;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            if ($urandom_range(99) < 3)
                tick_to($urandom_range(SLOTS - 1));
            else
                tick_to((cur_slot + $urandom_range(1, 12)) % SLOTS);
        end
        else if (pick < 70)
        begin
            case ($urandom_range(9))
                0:       wt = $urandom_range(65535);
                1:       wt = SLOTS * $urandom_range(1, 63);
                2:       wt = 0;
                3:       wt = $urandom_range(13, 2000);
                default: wt = $urandom_range(1, 40);
            endcase
            send_word(ACT_START, $urandom_range(15), wt, $urandom, $urandom);
        end
        else if (pick < 80)
            send_word(ACT_STOP, $urandom_range(15), $urandom, $urandom, $urandom);
        else
            send_word(ACT_READ, $urandom_range(15), $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        int phase_in [3];
        int phase_out[3];
        phase_in  = '{9, 54, 0};
        phase_out = '{54, 9, 0};
        rst_n             = 1'b0;
        idle_in           = phase_in[0];
        idle_out          = phase_out[0];
        cur_slot          = SLOTS - 1;
        word_count        = 0;
        stall_cycles      = 0;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_TICK;
        in_ch.timer_id    = '0;
        in_ch.delay_ticks = '0;
        in_ch.tag         = '0;
        in_ch.frame_time  = '0;
        out_ch.ready      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_word(ACT_START, 0, 0, 16'h1234, 0);
        send_word(ACT_STOP, 3, 0, 0, 0);
        send_word(ACT_READ, 4, 0, 0, 0);
        send_word(ACT_START, 0, 1, 16'hffff, 0);
        send_word(ACT_START, 15, 65535, 0, 0);
        send_word(ACT_START, 1, SLOTS, 16'haaaa, 0);
        send_word(ACT_START, 2, 2 * SLOTS, 16'h5555, 0);
        send_word(ACT_START, 5, 3, 16'h0101, 0);
        send_word(ACT_START, 5, 2, 16'h0202, 0);
        send_word(ACT_START, 6, 2, 16'h0303, 0);
        send_word(ACT_START, 7, 9, 16'h0404, 0);
        send_word(ACT_READ, 15, 0, 0, 0);
        send_word(ACT_STOP, 7, 0, 0, 0);
        send_word(ACT_READ, 7, 0, 0, 0);
        tick_to(0);
        tick_to(3);
        send_word(ACT_START, 8, 20, 16'hbeef, 0);
        send_word(ACT_READ, 8, 0, 0, 0);
        tick_to(SLOTS - 1);
        tick_to(SLOTS - 1);
        tick_to(1023);

        for (int p = 0; p < 3; p++)
        begin
            idle_in  = phase_in[p];
            idle_out = phase_out[p];
            repeat (83) random_word();
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("run: %0d input words, %0d timer expiries, ticks with wraparound catch-up",
                 word_count, fire_count);
        $display("start/stop/read errors, restarts and exact-multiple waits exercised");
        if (errors == 0 && pending == 0)
            $display("hashed_timer_wheel regression: pass");
        else
            $display("hashed_timer_wheel regression: fail");
        $finish;
    end

endmodule
